FILE: sv/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// used by tcw_ctrl, tcw_datapath and text_console_writer; no dependencies
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0a;
    localparam logic [7:0]  SPACE_BYTE   = 8'h20;
    localparam logic [7:0]  RESET_ATTR   = 8'h02;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic put;
        logic clear_home;
        logic rd_item;
        logic copy;
        logic fill;
        logic fill_reset;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  need_scroll;
        logic  copy_last;
        logic  fill_last;
        logic  out_free;
    } sts_t;

endpackage

FILE: sv/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg; drives tcw_datapath through cmd_t, watches sts_t
module tcw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tcw_pkg::sts_t sts,
    output tcw_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.fill       = 1'b1;
                cmd.fill_reset = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.cnt_clr = 1'b1;
                case (sts.func)
                    tcw_pkg::FUNC_PUT: begin
                        cmd.put    = 1'b1;
                        state_next = sts.need_scroll ? ST_COPY : ST_DONE;
                    end
                    tcw_pkg::FUNC_CLEAR: begin
                        cmd.clear_home = 1'b1;
                        state_next     = ST_FILL;
                    end
                    tcw_pkg::FUNC_READ: begin
                        cmd.rd_item = 1'b1;
                        state_next  = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_COPY: begin
                cmd.copy = 1'b1;
                if (sts.copy_last) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register still full");

    a_scroll_starts_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && sts.need_scroll) |=> cmd.copy)
        else $error("scroll did not start the row copy");

    a_copy_to_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.copy && sts.copy_last) |=> (cmd.fill && !cmd.fill_reset))
        else $error("row copy not followed by bottom row fill");
`endif

endmodule

FILE: sv/tcw_datapath.sv
// tcw_datapath: screen memory, cursor, sweep counter and result register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tcw_pkg::cmd_t cmd,
    output tcw_pkg::sts_t sts,
    input  logic [1:0]    in_func,
    input  logic [7:0]    in_char,
    input  logic [10:0]   in_idx,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   out_cell,
    output logic [4:0]    out_row,
    output logic [6:0]    out_col,
    output logic          out_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] FILL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] cnt_reg;
    logic [7:0]    color_reg;

    tcw_pkg::func_t func_reg;
    logic [7:0]    char_reg;
    logic [AW-1:0] idx_reg;
    logic          in_range_reg;
    logic          scrolled_reg;

    logic          m_tvalid_reg;
    logic [15:0]   cell_reg;
    logic [4:0]    orow_reg;
    logic [6:0]    ocol_reg;
    logic          oscr_reg;

    logic          is_nl;
    logic          advance;
    logic          last_row;
    logic [AW-1:0] pos;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign is_nl    = (char_reg == tcw_pkg::NEWLINE_BYTE);
    assign advance  = is_nl || (col_reg == LAST_COL);
    assign last_row = (row_reg == LAST_ROW);
    assign pos      = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));

    assign sts.func        = func_reg;
    assign sts.need_scroll = advance && last_row;
    assign sts.copy_last   = (cnt_reg == COPY_LAST);
    assign sts.fill_last   = (cnt_reg == FILL_LAST);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = {color_reg, tcw_pkg::SPACE_BYTE};
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        if (cmd.put && !is_nl) begin
            wr_en   = 1'b1;
            wr_addr = pos;
            wr_data = {color_reg, char_reg};
        end else if (cmd.copy) begin
            wr_en   = (cnt_reg != '0);
            wr_addr = cnt_reg - AW'(1);
            wr_data = rdata_reg;
            rd_en   = !sts.copy_last;
            rd_addr = cnt_reg + ROW_STEP;
        end else if (cmd.fill) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = cmd.fill_reset ? {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_BYTE}
                                     : {color_reg, tcw_pkg::SPACE_BYTE};
        end else if (cmd.rd_item) begin
            rd_en   = in_range_reg;
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg     <= tcw_pkg::func_t'(in_func);
            char_reg     <= in_char;
            idx_reg      <= AW'(in_idx);
            in_range_reg <= (32'(in_idx) < CELLS);
        end
        if (cmd.out_load) begin
            cell_reg <= (func_reg == tcw_pkg::FUNC_READ && in_range_reg) ? rdata_reg : 16'h0000;
            orow_reg <= 5'(row_reg);
            ocol_reg <= 7'(col_reg);
            oscr_reg <= scrolled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            color_reg    <= tcw_pkg::RESET_ATTR;
            scrolled_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                scrolled_reg <= 1'b0;
            end else if (cmd.put) begin
                scrolled_reg <= advance && last_row;
            end
            if (cmd.clear_home) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (cmd.put) begin
                if (advance) begin
                    col_reg <= '0;
                    if (!last_row) begin
                        row_reg <= row_reg + RW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if ((cmd.copy && !sts.copy_last) || (cmd.fill && !sts.fill_last)) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign out_cell     = cell_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign out_scrolled = oscr_reg;

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_clear_homes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_home |=> (row_reg == '0 && col_reg == '0))
        else $error("clear did not home the cursor");
`endif

endmodule

FILE: sv/text_console_writer.sv
// text_console_writer: text-mode screen engine with cursor, scroll and clear
// depends on tcw_pkg, tcw_ctrl and tcw_datapath
//
// usage
//   s_ channel: one command per transfer; s_tuser selects put, clear, read
//   or no-op, s_tdata carries the character and the cell index to read
//   m_ channel: exactly one result per command, cell value and cursor after it
//   cfg_wr_en / cfg_wr_data: color attribute, write only while idle
// sequence
//   put character, newline, read, no-op: accept, execute and result-load steps
//   of the controller
//   scroll, clear: the single write port of the screen memory walks every
//   cell
// reset
//   aresetn low homes the cursor and sets the attribute to 0x02; after it a
//   clearing pass fills the memory with 0x0220 while s_tready stays low
//   (configuration writes are still taken)
// back pressure
//   a result waits in the output register while m_tready is low; one more
//   command is taken and held until the register frees
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero[23:19]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_value[15:0], cursor_row_out[20:16],
                                   // cursor_col_out[27:21], scrolled[28], zero[31:29]
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    tcw_pkg::cmd_t cmd;
    tcw_pkg::sts_t sts;

    logic [15:0] out_cell;
    logic [4:0]  out_row;
    logic [6:0]  out_col;
    logic        out_scrolled;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_func      (s_tuser),
        .in_char      (s_tdata[7:0]),
        .in_idx       (s_tdata[18:8]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_cell     (out_cell),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_scrolled (out_scrolled)
    );

    assign m_tdata = {3'b000, out_scrolled, out_col, out_row, out_cell};

endmodule

FILE: test/tb.sv
// tb: self-checking bench for text_console_writer; a mirror of the screen store,
// cursor and color attribute predicts every result of directed and random commands
// depends on tcw_pkg and text_console_writer
module tb;

    localparam int COLS         = tcw_pkg::DEF_COLUMNS;
    localparam int LINES        = tcw_pkg::DEF_ROWS;
    localparam int CELLS        = COLS * LINES;
    localparam int LIMIT_CYCLES = 30000000;

    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  row;
        logic [6:0]  col;
        logic        scrolled;
    } console_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    logic [15:0]     screen_mirror [CELLS];
    int              cur_row;
    int              cur_col;
    logic [7:0]      attr_mirror;
    console_result_t pending_results [$];

    int cycle_count = 0;
    int failures    = 0;
    int items_sent  = 0;
    int hold_left   = 0;
    bit no_idle     = 1'b0;

    text_console_writer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // cursor to start of next line, scrolling the mirror when past the bottom
    function automatic logic next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= LINES) begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_mirror[i] = screen_mirror[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_mirror[i] = {attr_mirror, tcw_pkg::SPACE_BYTE};
            cur_row = LINES - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic console_result_t apply_console_command(tcw_pkg::func_t f,
                                                              logic [7:0] ch,
                                                              logic [10:0] idx);
        console_result_t r;
        r = '0;
        case (f)
            tcw_pkg::FUNC_PUT: begin
                if (ch == tcw_pkg::NEWLINE_BYTE) begin
                    r.scrolled = next_line();
                end else begin
                    screen_mirror[cur_row * COLS + cur_col] = {attr_mirror, ch};
                    cur_col++;
                    if (cur_col >= COLS)
                        r.scrolled = next_line();
                end
            end
            tcw_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_mirror[i] = {attr_mirror, tcw_pkg::SPACE_BYTE};
                cur_row = 0;
                cur_col = 0;
            end
            tcw_pkg::FUNC_READ: begin
                if (idx < CELLS)
                    r.cell_val = screen_mirror[idx];
            end
            default: ;
        endcase
        r.row = cur_row[4:0];
        r.col = cur_col[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
                 what, cycle_count, want, got);
        failures++;
    endtask

    // result checking and prediction at every transfer
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end else begin
            if (cfg_wr_en)
                attr_mirror = cfg_wr_data;
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[20:16], m_tdata[27:21], m_tdata[28]};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.cell_val !== want.cell_val)
                        report_mismatch("cell_value", want.cell_val, got.cell_val);
                    if (got.row !== want.row)
                        report_mismatch("cursor_row_out", want.row, got.row);
                    if (got.col !== want.col)
                        report_mismatch("cursor_col_out", want.col, got.col);
                    if (got.scrolled !== want.scrolled)
                        report_mismatch("scrolled", want.scrolled, got.scrolled);
                end
            end
            if (aresetn && s_tvalid && s_tready)
                pending_results.push_back(apply_console_command(tcw_pkg::func_t'(s_tuser),
                                                                s_tdata[7:0], s_tdata[18:8]));
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    task automatic send_command(tcw_pkg::func_t f, logic [7:0] ch, logic [10:0] idx);
        while (!no_idle && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'b0, idx, ch};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_attribute(logic [7:0] a);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [10:0] any_index();
        return 11'($urandom_range(2047));
    endfunction

    // mostly cells just behind the cursor, where text was written last
    function automatic logic [10:0] near_cursor_index();
        int pos;
        pos = cur_row * COLS + cur_col - $urandom_range(COLS + 2) + $urandom_range(3);
        if (pos < 0)
            pos = 0;
        if (pos >= CELLS)
            pos = CELLS - 1;
        return 11'(pos);
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(7) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    task automatic test_reset_state();
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
        send_command(tcw_pkg::FUNC_READ, 8'hff, 11'd1);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1));
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'(CELLS));
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'h7ff);
        send_command(tcw_pkg::FUNC_NOP, 8'hff, 11'h7ff);
    endtask

    task automatic test_put_extremes();
        send_command(tcw_pkg::FUNC_PUT, 8'h00, 11'h7ff);
        send_command(tcw_pkg::FUNC_PUT, 8'hff, 11'd0);
        send_command(tcw_pkg::FUNC_PUT, 8'h7f, 11'h555);
        send_command(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_BYTE, 11'h2aa);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'd1);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'd2);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'(COLS));
        send_command(tcw_pkg::FUNC_PUT, 8'h41, 11'd0);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'(COLS));
        send_command(tcw_pkg::FUNC_CLEAR, 8'hff, 11'h7ff);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'd0);
        send_command(tcw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1));
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_left = 400;
        repeat (16) begin
            if ($urandom_range(1))
                send_command(tcw_pkg::FUNC_PUT, text_byte(), any_index());
            else
                send_command(tcw_pkg::FUNC_READ, 8'($urandom_range(255)),
                             near_cursor_index());
        end
    endtask

    task automatic test_drain_pause();
        repeat (10) send_command(tcw_pkg::FUNC_PUT, text_byte(), any_index());
        wait_idle();
        repeat (10) send_command(tcw_pkg::FUNC_READ, 8'($urandom_range(255)),
                                 near_cursor_index());
    endtask

    task automatic test_random_text(int n);
        int start;
        int len;
        int pick;
        start = items_sent;
        while (items_sent - start < n) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                case ($urandom_range(9))
                    0: len = COLS - 1;
                    1: len = COLS;
                    2: len = COLS + 1;
                    3: len = $urandom_range(2 * COLS);
                    default: len = $urandom_range(1, 30);
                endcase
                repeat (len) send_command(tcw_pkg::FUNC_PUT, text_byte(), any_index());
                if ($urandom_range(9) < 7)
                    send_command(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_BYTE, any_index());
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4))
                    send_command(tcw_pkg::FUNC_READ, 8'($urandom_range(255)),
                                 near_cursor_index());
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3))
                    send_command(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_BYTE, any_index());
            end else if (pick < 88) begin
                send_command(tcw_pkg::FUNC_CLEAR, 8'($urandom_range(255)), any_index());
            end else if (pick < 92) begin
                send_command(tcw_pkg::FUNC_NOP, 8'($urandom_range(255)), any_index());
            end else begin
                send_command(tcw_pkg::FUNC_READ, 8'($urandom_range(255)), any_index());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_BYTE};
        cur_row     = 0;
        cur_col     = 0;
        attr_mirror = tcw_pkg::RESET_ATTR;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_put_extremes();
        set_attribute(8'hff);
        test_random_text(230);
        set_attribute(8'h00);
        test_random_text(230);
        test_backpressure();
        set_attribute(8'h0f);
        no_idle = 1'b1;
        test_random_text(230);
        no_idle = 1'b0;
        test_drain_pause();
        set_attribute(8'hf0);
        test_random_text(230);
        repeat (4) begin
            set_attribute(8'($urandom_range(255)));
            test_random_text(200);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
